[rtl/mdmip_pkg.sv]
// Shared types, constants and helpers for the min-depth mip downsampler.
// Used by mdmip_line_buf and min_depth_mip_downsample.
`timescale 1ns / 1ps

package mdmip_pkg;

	// Field widths
	localparam int DEPTH_W    = 16;
	localparam int COORD_W    = 11;
	localparam int CFG_SIZE_W = 13;

	// Register port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CFG_SIZE_W-1:0] cfg_size_t;

	// Register indexes (byte address / 4)
	typedef enum logic [1:0] {
		REG_LEVEL_WIDTH   = 2'd0,
		REG_LEVEL_HEIGHT  = 2'd1,
		REG_NEGATIVE_FACE = 2'd2
	} reg_idx_t;

	function automatic depth_t depth_min(input depth_t a, input depth_t b);
		return (a < b) ? a : b;
	endfunction

endpackage

[rtl/mdmip_line_buf.sv]
// Line buffer holding the horizontal pair minima of the last even row.
// One write and one registered read per cycle, with write-to-read forwarding.
// Depends on mdmip_pkg.
`timescale 1ns / 1ps

module mdmip_line_buf #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  mdmip_pkg::depth_t   wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output mdmip_pkg::depth_t   rd_data
);

	mdmip_pkg::depth_t mem [DEPTH];
	mdmip_pkg::depth_t ram_q;
	mdmip_pkg::depth_t fwd_data_q;
	logic              fwd_q;

	// Storage: write first in program order, read returns old contents
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			ram_q      <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// Same-entry write and read in one cycle: hand the new data over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : ram_q;

endmodule

[rtl/min_depth_mip_downsample.sv]
// Top level of the hierarchical-Z 2x2 min mip downsampler.
// Depends on mdmip_pkg and mdmip_line_buf.
`timescale 1ns / 1ps

// Accepts one 16-bit depth texel per cycle in raster order and emits the next
// coarser mip level, one min-of-2x2 texel per output item, in raster order,
// with its column, row and a flag on the last texel of the level. Throughput
// is one texel per cycle. A texel that completes a block enters the line
// buffer stage at the edge that accepts it, and its result is loaded into the
// output register as soon as it is free. The input stalls only while a result
// waits in that stage behind a full output register that out_ready has not
// emptied. Horizontal pairs are folded in a single accumulator, and the line
// buffer (MAX_WIDTH/2 entries, one write and one read port) keeps the
// even-row pair minima until the odd row reads them back. Level width, height
// and face orientation are set through the register port at byte addresses
// 0, 4 and 8; any write there restarts the level, and writes are expected
// only while the block is idle. Zero sizes act as 1 and sizes above the
// maximum saturate.
module min_depth_mip_downsample #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdmip_pkg::APB_AW-1:0]  paddr,
	input  logic [mdmip_pkg::APB_DW-1:0]  pwdata,
	output logic [mdmip_pkg::APB_DW-1:0]  prdata,
	output logic                          pready,
	// input texels
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mdmip_pkg::depth_t             texel,
	// output texels
	output logic                          out_valid,
	input  logic                          out_ready,
	output mdmip_pkg::depth_t             min_depth,
	output mdmip_pkg::coord_t             out_col,
	output mdmip_pkg::coord_t             out_row,
	output logic                          level_done
);

	localparam int LD = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
	localparam int PW = (LD > 1) ? $clog2(LD) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	typedef struct packed {
		logic                  wr;
		logic                  rd;
		logic                  emit;
		logic                  done;
		logic [PW-1:0]         addr;
		mdmip_pkg::coord_t     col;
		mdmip_pkg::coord_t     row;
		mdmip_pkg::depth_t     pmin;
	} pair_t;

	// Configuration registers
	mdmip_pkg::cfg_size_t level_width_q;
	mdmip_pkg::cfg_size_t level_height_q;
	logic                 negative_face_q;

	// Raster position and horizontal accumulator
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	mdmip_pkg::depth_t acc_q;

	// Pipeline
	logic              s1_valid;
	pair_t             s1;
	pair_t             pair_s0;
	logic              have_pair;
	mdmip_pkg::depth_t line_rd;
	mdmip_pkg::depth_t s1_val;
	logic              out_valid_q;
	mdmip_pkg::depth_t min_depth_q;
	mdmip_pkg::coord_t out_col_q;
	mdmip_pkg::coord_t out_row_q;
	logic              level_done_q;

	logic cfg_wr;
	logic cfg_hit;
	logic in_fire;
	logic s1_adv;
	logic out_free;

	// Level geometry
	logic [WW-1:0] w_c;
	logic [HW-1:0] h_c;
	logic [WW-1:0] wo;
	logic [HW-1:0] ho;
	logic          offset;
	logic [CW-1:0] k;
	logic [CW-1:0] p_full;
	logic [RW-1:0] r_half;
	logic          h_pair_ok;
	logic          k_odd;
	logic          v_ok;
	logic          acc_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register writes; a write to a known register restarts the level
	always_comb begin
		cfg_hit = 1'b0;
		case (paddr[3:2])
			mdmip_pkg::REG_LEVEL_WIDTH:   cfg_hit = 1'b1;
			mdmip_pkg::REG_LEVEL_HEIGHT:  cfg_hit = 1'b1;
			mdmip_pkg::REG_NEGATIVE_FACE: cfg_hit = 1'b1;
			default:                      cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_width_q   <= mdmip_pkg::cfg_size_t'(1);
			level_height_q  <= mdmip_pkg::cfg_size_t'(1);
			negative_face_q <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				mdmip_pkg::REG_LEVEL_WIDTH:
					level_width_q <= pwdata[mdmip_pkg::CFG_SIZE_W-1:0];
				mdmip_pkg::REG_LEVEL_HEIGHT:
					level_height_q <= pwdata[mdmip_pkg::CFG_SIZE_W-1:0];
				mdmip_pkg::REG_NEGATIVE_FACE:
					negative_face_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		case (paddr[3:2])
			mdmip_pkg::REG_LEVEL_WIDTH:   prdata = mdmip_pkg::APB_DW'(level_width_q);
			mdmip_pkg::REG_LEVEL_HEIGHT:  prdata = mdmip_pkg::APB_DW'(level_height_q);
			mdmip_pkg::REG_NEGATIVE_FACE: prdata = mdmip_pkg::APB_DW'(negative_face_q);
			default:                      prdata = '0;
		endcase
	end

	// Clamped sizes, output sizes and right-edge anchoring
	always_comb begin
		if (level_width_q == '0)
			w_c = WW'(1);
		else if (32'(level_width_q) > 32'(MAX_WIDTH))
			w_c = WW'(MAX_WIDTH);
		else
			w_c = WW'(level_width_q);
		if (level_height_q == '0)
			h_c = HW'(1);
		else if (32'(level_height_q) > 32'(MAX_HEIGHT))
			h_c = HW'(MAX_HEIGHT);
		else
			h_c = HW'(level_height_q);
		wo     = ((w_c >> 1) == '0) ? WW'(1) : (w_c >> 1);
		ho     = ((h_c >> 1) == '0) ? HW'(1) : (h_c >> 1);
		offset = negative_face_q && (w_c != WW'(1)) && w_c[0];
	end

	// Horizontal and vertical pairing for the texel at the input
	always_comb begin
		k         = col_q - CW'(offset);
		p_full    = (w_c == WW'(1)) ? '0 : (k >> 1);
		k_odd     = k[0];
		r_half    = row_q >> 1;
		h_pair_ok = 1'b0;
		acc_load  = 1'b0;
		pair_s0   = '0;

		if (w_c == WW'(1)) begin
			h_pair_ok    = (col_q == '0);
			pair_s0.pmin = texel;
		end else if (col_q >= CW'(offset) && WW'(k >> 1) < wo) begin
			if (!k_odd) begin
				acc_load = 1'b1;
			end else begin
				h_pair_ok    = 1'b1;
				pair_s0.pmin = mdmip_pkg::depth_min(acc_q, texel);
			end
		end

		pair_s0.addr = p_full[PW-1:0];
		pair_s0.col  = mdmip_pkg::COORD_W'(p_full);
		if (h_c == HW'(1)) begin
			v_ok         = (row_q == '0);
			pair_s0.emit = v_ok;
			pair_s0.row  = '0;
		end else begin
			v_ok         = HW'(r_half) < ho;
			pair_s0.wr   = v_ok && !row_q[0];
			pair_s0.rd   = v_ok && row_q[0];
			pair_s0.emit = v_ok && row_q[0];
			pair_s0.row  = mdmip_pkg::COORD_W'(r_half);
		end
		pair_s0.done = (WW'(p_full) == wo - WW'(1)) &&
			(((h_c == HW'(1)) ? HW'(0) : HW'(r_half)) == ho - HW'(1));
		have_pair = h_pair_ok && v_ok;
	end

	// Flow control
	assign out_free = !out_valid_q || out_ready;
	assign s1_adv   = s1_valid && (!s1.emit || out_free);
	assign in_ready = !s1_valid || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// Raster counters and pair accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			acc_q <= '1;
		end else if (cfg_wr && cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
			acc_q <= '1;
		end else if (in_fire) begin
			if (acc_load) begin
				acc_q <= texel;
			end
			if (WW'(col_q) == w_c - WW'(1)) begin
				col_q <= '0;
				row_q <= (HW'(row_q) == h_c - HW'(1)) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: line buffer access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_fire && have_pair;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && have_pair) begin
			s1 <= pair_s0;
		end
	end

	mdmip_line_buf #(
		.DEPTH (LD),
		.AW    (PW)
	) u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s1_adv && s1.wr),
		.wr_addr (s1.addr),
		.wr_data (s1.pmin),
		.rd_en   (in_fire && have_pair),
		.rd_addr (pair_s0.addr),
		.rd_data (line_rd)
	);

	assign s1_val = s1.rd ? mdmip_pkg::depth_min(line_rd, s1.pmin) : s1.pmin;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1.emit) begin
			min_depth_q  <= s1_val;
			out_col_q    <= s1.col;
			out_row_q    <= s1.row;
			level_done_q <= s1.done;
		end
	end

	assign out_valid  = out_valid_q;
	assign min_depth  = min_depth_q;
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign level_done = level_done_q;

	// Checks
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < w_c)
		else $error("column counter beyond level width");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		HW'(row_q) < h_c)
		else $error("row counter beyond level height");

	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid |-> !(s1.wr && s1.rd))
		else $error("line buffer entry both written and read by one pair");

	a_pair_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && have_pair) |=> s1_valid)
		else $error("accepted pair lost before line buffer stage");

endmodule
